FILE: rtl/pdr_pkg.sv
package pdr_pkg;

  localparam int DEF_SIGNAL_BINS  = 50;
  localparam int DEF_RATE_CLASSES = 8;

  localparam int ROW_W   = 3;
  localparam int SUM_W   = 18;
  localparam int CNT_W   = 10;
  localparam int SIG_W   = 8;
  localparam int RATIO_W = 16;

  localparam int DVD_W = CNT_W + RATIO_W;
  localparam int DVS_W = CNT_W;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [RATIO_W-1:0] RST_BLEND_WEIGHT = 16'd58982;
  localparam logic [RATIO_W-1:0] RST_HIGH_LIMIT   = 16'd62259;
  localparam logic [RATIO_W-1:0] RST_LOW_LIMIT    = 16'd3277;
  localparam logic [SIG_W-1:0]   RST_SIGNAL_OFS   = 8'd0;

  typedef enum logic [1:0] {
    REG_BLEND  = 2'd0,
    REG_HIGH   = 2'd1,
    REG_LOW    = 2'd2,
    REG_OFFSET = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AVG,
    ST_RATIO,
    ST_READ,
    ST_BLEND,
    ST_MIX,
    ST_SCAN,
    ST_WRITE,
    ST_QREAD,
    ST_QDATA,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/pdr_div.sv
module pdr_div import pdr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic              active;
  logic [STEP_W-1:0] step;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVD_W-1:0]  quo;

  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W-1:0] rem_next;
  logic [DVD_W-1:0] quo_next;

  always_comb begin
    trial    = {rem, quo[DVD_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    quo_next = {quo[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
        rem    <= '0;
        dvs    <= divisor;
        quo    <= dividend;
      end else if (active) begin
        rem  <= rem_next;
        quo  <= quo_next;
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/pdr_table_ewma_learner_core.sv
// Delivery-ratio table learner. A record word (mode 0) averages signal_sum over
// received_count, bins it against signal_offset, forms received/total in Q0.16,
// blends it into the table entry, clamps it and lifts it to the first stronger
// marked entry at a lower bin; a query word (mode 1) reads one entry, or gives
// high_limit for a signal above the bins. One word is in flight at a time;
// in_ready drops from acceptance until the result is handed to the output
// register, which may still hold an earlier result. A record runs two
// divisions on a shared serial divider at one quotient bit per cycle, 26 bits
// each, then a scan of the lower bins at one entry per cycle through the
// table's read port. After reset a clearing pass zeroes all SIGNAL_BINS *
// RATE_CLASSES entries (400 by default) before the first word is taken;
// register writes are taken throughout.
module pdr_table_ewma_learner_core import pdr_pkg::*; #(
  parameter int SIGNAL_BINS  = DEF_SIGNAL_BINS,
  parameter int RATE_CLASSES = DEF_RATE_CLASSES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [ROW_W-1:0]   rate_class,
  input  logic [SUM_W-1:0]   signal_sum,
  input  logic [CNT_W-1:0]   received_count,
  input  logic [CNT_W-1:0]   total_count,
  input  logic [SIG_W-1:0]   query_signal,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [RATIO_W-1:0] ratio_value,
  output logic               sample_stored,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int TABLE_SIZE = SIGNAL_BINS * RATE_CLASSES;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int BIN_W      = $clog2(SIGNAL_BINS);
  localparam int IDX_W      = $clog2(SIGNAL_BINS + 2);
  localparam int WORD_W     = RATIO_W + 1;

  localparam logic [ADDR_W-1:0] BINS_A     = ADDR_W'(SIGNAL_BINS);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(TABLE_SIZE - 1);
  localparam logic [4:0]        CLASSES_L  = 5'(RATE_CLASSES);
  localparam logic [SUM_W-1:0]  BINS_SUM   = SUM_W'(SIGNAL_BINS);
  localparam logic [SIG_W:0]    BINS_SIG   = (SIG_W + 1)'(SIGNAL_BINS);

  // configuration
  logic [RATIO_W-1:0] blend_weight;
  logic [RATIO_W-1:0] high_limit;
  logic [RATIO_W-1:0] low_limit;
  logic [SIG_W-1:0]   signal_offset;
  reg_idx_t           cfg_idx;

  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight  <= RST_BLEND_WEIGHT;
      high_limit    <= RST_HIGH_LIMIT;
      low_limit     <= RST_LOW_LIMIT;
      signal_offset <= RST_SIGNAL_OFS;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_BLEND:  blend_weight  <= pwdata[RATIO_W-1:0];
        REG_HIGH:   high_limit    <= pwdata[RATIO_W-1:0];
        REG_LOW:    low_limit     <= pwdata[RATIO_W-1:0];
        REG_OFFSET: signal_offset <= pwdata[SIG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BLEND:  prdata = {16'h0000, blend_weight};
      REG_HIGH:   prdata = {16'h0000, high_limit};
      REG_LOW:    prdata = {16'h0000, low_limit};
      REG_OFFSET: prdata = {24'h000000, signal_offset};
      default:    prdata = '0;
    endcase
  end

  // state and datapath registers
  state_t state, state_next;

  logic [ADDR_W-1:0]  clr_addr;
  logic [CNT_W-1:0]   rcv_q;
  logic [CNT_W-1:0]   tot_q;
  logic [ADDR_W-1:0]  base_q;
  logic [BIN_W-1:0]   bin_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [RATIO_W-1:0] ratio_q;
  logic               seen_q;
  logic signed [33:0] prod_q;
  logic [RATIO_W-1:0] p_q;
  logic [IDX_W-1:0]   idx_q;
  logic               pend_q;
  logic [RATIO_W-1:0] res_val;
  logic               res_stored;

  // shared divider
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;

  pdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // table: bit 16 marks a written entry
  logic [WORD_W-1:0] mem [TABLE_SIZE];
  logic [WORD_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // decode of the incoming word
  logic               accept;
  logic               row_ok;
  logic [ADDR_W-1:0]  base_now;
  logic               rec_ok;
  logic               q_below;
  logic [SIG_W-1:0]   q_diff;
  logic               q_above;

  assign accept   = in_valid && in_ready;
  assign row_ok   = {2'b00, rate_class} < CLASSES_L;
  assign base_now = ADDR_W'(ADDR_W'(rate_class) * BINS_A);
  assign rec_ok   = row_ok && (received_count != '0) && (total_count != '0);
  assign q_below  = query_signal < signal_offset;
  assign q_diff   = query_signal - signal_offset;
  assign q_above  = {1'b0, q_diff} >= BINS_SIG;

  // average check
  logic [SUM_W-1:0] avg;
  logic [SUM_W-1:0] avg_diff;
  logic             avg_ok;

  assign avg      = div_quo[SUM_W-1:0];
  assign avg_diff = avg - {{(SUM_W - SIG_W){1'b0}}, signal_offset};
  assign avg_ok   = (avg >= {{(SUM_W - SIG_W){1'b0}}, signal_offset}) && (avg_diff < BINS_SUM);

  // ratio saturation
  logic [RATIO_W-1:0] ratio_sat;
  assign ratio_sat = (div_quo[DVD_W-1:RATIO_W] != '0) ? '1 : div_quo[RATIO_W-1:0];

  // blend: w*old + (1-w)*ratio == ratio + w*(old - ratio)
  logic signed [16:0] wt_s;
  logic signed [16:0] diff_s;
  logic signed [33:0] acc;
  logic [RATIO_W-1:0] blended;
  logic [RATIO_W-1:0] pre;
  logic [RATIO_W-1:0] clamped;

  always_comb begin
    wt_s    = $signed({1'b0, blend_weight});
    diff_s  = $signed({1'b0, rdata[RATIO_W-1:0]}) - $signed({1'b0, ratio_q});
    acc     = $signed({2'b00, ratio_q, 16'h0000}) + prod_q + 34'sd32768;
    blended = acc[31:16];
    pre     = seen_q ? blended : ratio_q;
    if (pre > high_limit) begin
      clamped = high_limit;
    end else if (pre < low_limit) begin
      clamped = '0;
    end else begin
      clamped = pre;
    end
  end

  // scan of lower bins
  logic scan_more;
  logic hit;

  assign scan_more = idx_q < IDX_W'(bin_q);
  assign hit       = pend_q && rdata[RATIO_W] && (rdata[RATIO_W-1:0] > p_q);

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (mode) begin
            state_next = (row_ok && !q_below && !q_above) ? ST_QREAD : ST_DONE;
          end else begin
            state_next = rec_ok ? ST_AVG : ST_DONE;
          end
        end
      end
      ST_AVG: begin
        if (div_done) state_next = avg_ok ? ST_RATIO : ST_DONE;
      end
      ST_RATIO: begin
        if (div_done) state_next = ST_READ;
      end
      ST_READ:  state_next = ST_BLEND;
      ST_BLEND: state_next = ST_MIX;
      ST_MIX:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (hit || (!scan_more && !pend_q)) state_next = ST_WRITE;
      end
      ST_WRITE: state_next = ST_DONE;
      ST_QREAD: state_next = ST_QDATA;
      ST_QDATA: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_dvd   = {{(DVD_W - SUM_W){1'b0}}, signal_sum};
    div_dvs   = received_count;
    raddr     = addr_q;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = {1'b1, p_q};
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = accept && !mode && rec_ok;
      end
      ST_AVG: begin
        div_start = div_done && avg_ok;
        div_dvd   = {rcv_q, 16'h0000};
        div_dvs   = tot_q;
      end
      ST_SCAN: begin
        if (scan_more) raddr = base_q + ADDR_W'(idx_q);
      end
      ST_WRITE: we = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rcv_q      <= received_count;
        tot_q      <= total_count;
        base_q     <= base_now;
        addr_q     <= base_now + ADDR_W'(q_diff);
        res_stored <= 1'b0;
        if (mode && row_ok && !q_below) begin
          res_val <= high_limit;
        end else begin
          res_val <= '0;
        end
      end
      ST_AVG: begin
        bin_q  <= avg_diff[BIN_W-1:0];
        addr_q <= base_q + ADDR_W'(avg_diff[BIN_W-1:0]);
      end
      ST_RATIO: ratio_q <= ratio_sat;
      ST_BLEND: begin
        seen_q <= rdata[RATIO_W];
        prod_q <= 34'(wt_s) * 34'(diff_s);
      end
      ST_MIX: begin
        p_q    <= clamped;
        idx_q  <= '0;
        pend_q <= 1'b0;
      end
      ST_SCAN: begin
        if (hit) p_q <= rdata[RATIO_W-1:0];
        pend_q <= scan_more;
        idx_q  <= idx_q + 1'b1;
      end
      ST_WRITE: begin
        res_val    <= p_q;
        res_stored <= 1'b1;
      end
      ST_QDATA: res_val <= rdata[RATIO_W-1:0];
      default:  ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      ratio_value   <= res_val;
      sample_stored <= res_stored;
    end
  end

endmodule

FILE: rtl/pdr_core_check.sv
module pdr_core_check import pdr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [RATIO_W-1:0] ratio_value,
  input logic               sample_stored,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata
);

  // table clearing keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open right after reset");

  // one word at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open the cycle after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ratio_value)
      && $stable(sample_stored)))
    else $error("result changed while stalled");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[3:2] == REG_BLEND) ##1 (paddr[3:2] == REG_BLEND)
      |-> prdata[RATIO_W-1:0] == $past(pwdata[RATIO_W-1:0]))
    else $error("blend weight readback mismatch");

endmodule

bind pdr_table_ewma_learner_core pdr_core_check u_check (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pdr_pkg::*;

  localparam int BINS    = DEF_SIGNAL_BINS;
  localparam int CLASSES = DEF_RATE_CLASSES;

  typedef struct {
    logic             mode;
    logic [ROW_W-1:0] row;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] rcv;
    logic [CNT_W-1:0] tot;
    logic [SIG_W-1:0] qsig;
  } pdr_word_t;

  typedef struct {
    logic [RATIO_W-1:0] ratio;
    logic               stored;
  } pdr_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = 1'b0;
  logic [ROW_W-1:0]   rate_class = '0;
  logic [SUM_W-1:0]   signal_sum = '0;
  logic [CNT_W-1:0]   received_count = '0;
  logic [CNT_W-1:0]   total_count = '0;
  logic [SIG_W-1:0]   query_signal = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [RATIO_W-1:0] ratio_value;
  logic               sample_stored;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  pdr_table_ewma_learner_core i_dut (.*);

  logic [RATIO_W-1:0] ratio_table [CLASSES][BINS];
  bit                 seen_table  [CLASSES][BINS];
  logic [RATIO_W-1:0] cfg_weight = RST_BLEND_WEIGHT;
  logic [RATIO_W-1:0] cfg_high   = RST_HIGH_LIMIT;
  logic [RATIO_W-1:0] cfg_low    = RST_LOW_LIMIT;
  logic [SIG_W-1:0]   cfg_offset = RST_SIGNAL_OFS;

  pdr_word_t   words_pending [$];
  pdr_result_t ratio_due [$];
  pdr_word_t   nxt;
  pdr_result_t due;
  bit          word_taken = 1'b0;
  int          send_gap = 0;
  int          hold_gap = 0;
  int          idle_odds = 4;
  int          mismatches = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic pdr_result_t learn_word(pdr_word_t w);
    pdr_result_t      r;
    int unsigned      avg;
    int unsigned      bin;
    int unsigned      ratio;
    int unsigned      p;
    longint unsigned  acc;
    r.ratio  = '0;
    r.stored = 1'b0;
    if (w.mode == 1'b0) begin
      if (w.rcv == 0 || w.tot == 0 || w.row >= CLASSES) return r;
      avg = 32'(w.sum) / 32'(w.rcv);
      if (avg < cfg_offset || avg - cfg_offset >= BINS) return r;
      bin = avg - cfg_offset;
      ratio = (32'(w.rcv) << 16) / 32'(w.tot);
      if (ratio > 65535) ratio = 65535;
      if (!seen_table[w.row][bin]) begin
        p = ratio;
      end else begin
        acc = 64'(cfg_weight) * 64'(ratio_table[w.row][bin])
            + 64'(65536 - 32'(cfg_weight)) * 64'(ratio) + 64'd32768;
        acc = acc >> 16;
        p = (acc > 65535) ? 65535 : 32'(acc);
      end
      if (p > cfg_high) p = cfg_high;
      else if (p < cfg_low) p = 0;
      for (int i = 0; i < bin; i++) begin
        if (seen_table[w.row][i] && ratio_table[w.row][i] > p) begin
          p = ratio_table[w.row][i];
          break;
        end
      end
      ratio_table[w.row][bin] = p[RATIO_W-1:0];
      seen_table[w.row][bin]  = 1'b1;
      r.ratio  = p[RATIO_W-1:0];
      r.stored = 1'b1;
    end else begin
      if (w.row >= CLASSES || w.qsig < cfg_offset) return r;
      bin = 32'(w.qsig) - 32'(cfg_offset);
      if (bin >= BINS) r.ratio = cfg_high;
      else r.ratio = ratio_table[w.row][bin];
    end
    return r;
  endfunction

  function automatic pdr_word_t noise_word();
    pdr_word_t w;
    w.mode = 1'($urandom_range(0, 1));
    w.row  = ROW_W'($urandom);
    w.sum  = SUM_W'($urandom);
    w.rcv  = CNT_W'($urandom);
    w.tot  = CNT_W'($urandom);
    w.qsig = SIG_W'($urandom);
    return w;
  endfunction

  function automatic pdr_word_t rec(int unsigned row, int unsigned sum, int unsigned rcv,
                                    int unsigned tot);
    pdr_word_t w;
    w = noise_word();
    w.mode = 1'b0;
    w.row  = ROW_W'(row);
    w.sum  = SUM_W'(sum);
    w.rcv  = CNT_W'(rcv);
    w.tot  = CNT_W'(tot);
    return w;
  endfunction

  function automatic pdr_word_t qry(int unsigned row, int unsigned qsig);
    pdr_word_t w;
    w = noise_word();
    w.mode = 1'b1;
    w.row  = ROW_W'(row);
    w.qsig = SIG_W'(qsig);
    return w;
  endfunction

  // in-bin record: sum is built from a target average so the bin is always hit
  function automatic pdr_word_t good_record();
    int unsigned avg;
    int unsigned rcv;
    int unsigned rcv_max;
    int unsigned tot;
    avg = 32'(cfg_offset) + $urandom_range(0, BINS - 1);
    rcv_max = 262144 / (avg + 1);
    if (rcv_max > 1023) rcv_max = 1023;
    if ($urandom_range(0, 3) == 0) rcv = $urandom_range(1, rcv_max);
    else rcv = $urandom_range(1, (rcv_max < 64) ? rcv_max : 64);
    case ($urandom_range(0, 9))
      0: tot = $urandom_range(1, rcv);
      1: tot = rcv;
      2: tot = $urandom_range(rcv, 1023);
      default: tot = $urandom_range(rcv, (4 * rcv > 1023) ? 1023 : 4 * rcv);
    endcase
    return rec($urandom_range(0, CLASSES - 1), avg * rcv + $urandom_range(0, rcv - 1),
               rcv, tot);
  endfunction

  function automatic pdr_word_t good_query();
    int unsigned sig;
    sig = 32'(cfg_offset) + $urandom_range(0, BINS - 1);
    if (sig > 255 || $urandom_range(0, 6) == 0) sig = $urandom_range(0, 255);
    return qry($urandom_range(0, CLASSES - 1), sig);
  endfunction

  task automatic fill_random(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick <= 10) words_pending.push_back(good_record());
      else if (pick <= 16) words_pending.push_back(good_query());
      else words_pending.push_back(noise_word());
    end
  endtask

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic set_reg(reg_idx_t idx, int unsigned value);
    logic [PDATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_BLEND:  cfg_weight = RATIO_W'(value);
      REG_HIGH:   cfg_high   = RATIO_W'(value);
      REG_LOW:    cfg_low    = RATIO_W'(value);
      REG_OFFSET: cfg_offset = SIG_W'(value);
      default:    ;
    endcase
    if (got != PDATA_W'(value)) note_mismatch("register readback", value, got);
  endtask

  task automatic apply_setting(int unsigned w, int unsigned h, int unsigned l,
                               int unsigned o);
    set_reg(REG_BLEND, w);
    set_reg(REG_HIGH, h);
    set_reg(REG_LOW, l);
    set_reg(REG_OFFSET, o);
  endtask

  task automatic settle();
    while (words_pending.size() != 0 || in_valid || ratio_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // sender and receiver, both change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || word_taken) begin
        word_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (words_pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          nxt = words_pending.pop_front();
          mode           <= nxt.mode;
          rate_class     <= nxt.row;
          signal_sum     <= nxt.sum;
          received_count <= nxt.rcv;
          total_count    <= nxt.tot;
          query_signal   <= nxt.qsig;
          in_valid       <= 1'b1;
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        hold_gap = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        ratio_due.push_back(learn_word(nxt));
        word_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (ratio_due.size() == 0) begin
          note_mismatch("result with no word pending", 0, ratio_value);
        end else begin
          due = ratio_due.pop_front();
          if (ratio_value !== due.ratio) note_mismatch("ratio_value", due.ratio, ratio_value);
          if (sample_stored !== due.stored)
            note_mismatch("sample_stored", due.stored, sample_stored);
        end
      end
    end
  end

  initial begin
    foreach (ratio_table[r, b]) begin
      ratio_table[r][b] = '0;
      seen_table[r][b]  = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_odds = 4;
    words_pending.push_back(qry(0, 0));
    words_pending.push_back(rec(0, 200, 20, 20));
    words_pending.push_back(rec(0, 215, 20, 40));
    words_pending.push_back(rec(0, 20, 1, 1023));
    words_pending.push_back(rec(1, 0, 1023, 1023));
    words_pending.push_back(rec(1, 0, 0, 5));
    words_pending.push_back(rec(1, 5, 5, 0));
    words_pending.push_back(rec(3, 200, 4, 4));
    words_pending.push_back(rec(7, 262143, 1023, 1023));
    words_pending.push_back(rec(7, 49999, 1000, 500));
    words_pending.push_back(rec(7, 49, 1, 1));
    words_pending.push_back(qry(0, 10));
    words_pending.push_back(qry(0, 20));
    words_pending.push_back(qry(7, 49));
    words_pending.push_back(qry(0, 50));
    words_pending.push_back(qry(5, 255));
    settle();

    set_reg(REG_OFFSET, 100);
    words_pending.push_back(rec(2, 495, 5, 5));
    words_pending.push_back(rec(2, 500, 5, 7));
    words_pending.push_back(qry(2, 99));
    words_pending.push_back(qry(2, 100));
    words_pending.push_back(qry(2, 150));
    settle();

    apply_setting(RST_BLEND_WEIGHT, RST_HIGH_LIMIT, RST_LOW_LIMIT, RST_SIGNAL_OFS);
    idle_odds = 3;
    fill_random(300);
    settle();

    apply_setting(0, 65535, 0, 0);
    idle_odds = 0;
    fill_random(200);
    settle();

    apply_setting(65535, 30000, 20000, 255);
    idle_odds = 6;
    fill_random(200);
    settle();

    apply_setting($urandom_range(0, 65535), $urandom_range(20000, 65535),
                  $urandom_range(0, 20000), $urandom_range(0, 255));
    idle_odds = 2;
    fill_random(200);
    settle();

    apply_setting($urandom_range(0, 65535), $urandom_range(20000, 65535),
                  $urandom_range(0, 20000), $urandom_range(0, 255));
    idle_odds = 10;
    fill_random(150);
    settle();

    apply_setting(RST_BLEND_WEIGHT, RST_HIGH_LIMIT, RST_LOW_LIMIT, RST_SIGNAL_OFS);
    idle_odds = 0;
    fill_random(150);
    settle();
    repeat (150) @(posedge clk);

    if (mismatches == 0 && ratio_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pdr_pkg.sv
rtl/pdr_div.sv
rtl/pdr_table_ewma_learner_core.sv
rtl/pdr_core_check.sv
bench/tb_top.sv
